// ===== src/lrd_pkg.sv =====
// Shared types and constants for the log record deframer.
// No dependencies; imported by lrd_parser, log_record_deframer_core and the testbench.
`default_nettype none

package lrd_pkg;

    // Width of the length fields and of the length arithmetic (8 to 32).
    localparam int LEN_BITS = 32;

    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [1:0]          role_t;
    typedef logic [1:0]          kind_t;

    // Byte roles.
    localparam role_t ROLE_HEADER  = 2'd0;
    localparam role_t ROLE_KEY     = 2'd1;
    localparam role_t ROLE_VALUE   = 2'd2;
    localparam role_t ROLE_IGNORED = 2'd3;

    // Record kinds reported with record_done.
    localparam kind_t KIND_SET    = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_OTHER  = 2'd2;

    // Command codes.
    localparam logic [7:0] CMD_SET    = 8'd1;
    localparam logic [7:0] CMD_REMOVE = 8'd3;

    // Fixed header sizes that enter the length check.
    localparam len_t LEN_FIELD_BYTES = len_t'(4);
    localparam len_t CMD_KEYLEN_BYTES = len_t'(5);

    // One input item.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        role_t      role;
        logic       done;
        kind_t      kind;
        logic       bad;
    } result_t;

endpackage

`default_nettype wire

// ===== src/lrd_parser.sv =====
// Record parser state machine: holds the deframing state and tags one byte per advance.
// Depends on lrd_pkg.
`default_nettype none

module lrd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lrd_pkg::item_t  item,
    input  wire logic            advance,
    output lrd_pkg::result_t     result
);
    import lrd_pkg::*;

    typedef enum logic [2:0] {
        PH_TOTAL  = 3'd0,
        PH_CMD    = 3'd1,
        PH_KEYLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_VALLEN = 3'd4,
        PH_VALUE  = 3'd5
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [1:0] fbc_reg,     fbc_next;
    len_t       total_reg,   total_next;
    logic [7:0] cmd_reg,     cmd_next;
    len_t       keylen_reg,  keylen_next;
    len_t       vallen_reg,  vallen_next;
    len_t       remain_reg,  remain_next;
    len_t       key_sum_reg, key_sum_next;
    len_t       val_sum_reg, val_sum_next;
    logic       halted_reg,  halted_next;

    phase_t     phase_cur;
    logic [1:0] fbc_cur;
    len_t       total_cur;
    logic       halted_cur;
    len_t       acc_in;
    len_t       acc_shift;
    logic       field_last;
    logic       is_set;
    logic       is_remove;
    len_t       remain_dec;
    logic       end_now;
    len_t       end_base;
    len_t       end_val;
    len_t       expect_len;

    always_comb
    begin
        // Log start resets the parser ahead of this byte.
        phase_cur  = item.start ? PH_TOTAL : phase_reg;
        fbc_cur    = item.start ? 2'd0 : fbc_reg;
        total_cur  = item.start ? '0 : total_reg;
        halted_cur = item.start ? 1'b0 : halted_reg;

        is_set     = (cmd_reg == CMD_SET);
        is_remove  = (cmd_reg == CMD_REMOVE);
        remain_dec = remain_reg - len_t'(1);
        field_last = (fbc_cur == 2'd3);

        case (phase_cur)
            PH_KEYLEN: acc_in = keylen_reg;
            PH_VALLEN: acc_in = vallen_reg;
            default:   acc_in = (phase_cur == PH_TOTAL) ? total_cur : '0;
        endcase
        acc_shift = len_t'({acc_in, item.data});

        phase_next   = phase_cur;
        fbc_next     = fbc_cur;
        total_next   = total_cur;
        cmd_next     = cmd_reg;
        keylen_next  = keylen_reg;
        vallen_next  = vallen_reg;
        remain_next  = remain_reg;
        key_sum_next = key_sum_reg;
        val_sum_next = val_sum_reg;
        halted_next  = halted_cur;
        end_now      = 1'b0;

        result.data = item.data;
        result.role = ROLE_HEADER;
        result.done = 1'b0;
        result.kind = KIND_SET;
        result.bad  = 1'b0;

        // Base of the expected total: 5 plus key length, zero key on the length byte.
        end_base = (phase_cur == PH_KEYLEN) ? CMD_KEYLEN_BYTES : key_sum_reg;
        end_val  = (phase_cur == PH_VALUE) ? val_sum_reg : LEN_FIELD_BYTES;

        if (halted_cur)
        begin
            result.role = ROLE_IGNORED;
        end
        else
        begin
            case (phase_cur)
                PH_CMD:
                begin
                    cmd_next    = item.data;
                    keylen_next = '0;
                    fbc_next    = 2'd0;
                    phase_next  = PH_KEYLEN;
                end
                PH_KEYLEN:
                begin
                    keylen_next  = acc_shift;
                    key_sum_next = CMD_KEYLEN_BYTES + acc_shift;
                    fbc_next     = fbc_cur + 2'd1;
                    if (field_last)
                    begin
                        if (acc_shift != '0)
                        begin
                            remain_next = acc_shift;
                            phase_next  = PH_KEY;
                        end
                        else if (is_set)
                        begin
                            vallen_next = '0;
                            phase_next  = PH_VALLEN;
                        end
                        else
                        begin
                            end_now = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    result.role = ROLE_KEY;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        if (is_set)
                        begin
                            fbc_next    = 2'd0;
                            vallen_next = '0;
                            phase_next  = PH_VALLEN;
                        end
                        else
                        begin
                            end_now = 1'b1;
                        end
                    end
                end
                PH_VALLEN:
                begin
                    vallen_next  = acc_shift;
                    val_sum_next = LEN_FIELD_BYTES + acc_shift;
                    fbc_next     = fbc_cur + 2'd1;
                    if (field_last)
                    begin
                        if (acc_shift != '0)
                        begin
                            remain_next = acc_shift;
                            phase_next  = PH_VALUE;
                        end
                        else
                        begin
                            end_now = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                begin
                    result.role = ROLE_VALUE;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        end_now = 1'b1;
                    end
                end
                default:
                begin
                    // Total length field; unused phase codes restart here.
                    if (phase_cur != PH_TOTAL)
                    begin
                        acc_shift  = len_t'({8'd0, item.data});
                        fbc_next   = 2'd1;
                        total_next = acc_shift;
                        phase_next = PH_TOTAL;
                    end
                    else
                    begin
                        total_next = acc_shift;
                        fbc_next   = fbc_cur + 2'd1;
                        if (field_last)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                end
            endcase
        end

        // Record end: check set and remove lengths, pass everything else.
        expect_len = end_base + (is_set ? end_val : '0);
        if (end_now)
        begin
            phase_next = PH_TOTAL;
            fbc_next   = 2'd0;
            total_next = '0;
            if (is_set || is_remove)
            begin
                if (expect_len != total_cur)
                begin
                    result.bad  = 1'b1;
                    halted_next = 1'b1;
                end
                else
                begin
                    result.done = 1'b1;
                    result.kind = is_set ? KIND_SET : KIND_REMOVE;
                end
            end
            else
            begin
                result.done = 1'b1;
                result.kind = KIND_OTHER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOTAL;
            fbc_reg     <= 2'd0;
            total_reg   <= '0;
            cmd_reg     <= '0;
            keylen_reg  <= '0;
            vallen_reg  <= '0;
            remain_reg  <= '0;
            key_sum_reg <= '0;
            val_sum_reg <= '0;
            halted_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            total_reg   <= total_next;
            cmd_reg     <= cmd_next;
            keylen_reg  <= keylen_next;
            vallen_reg  <= vallen_next;
            remain_reg  <= remain_next;
            key_sum_reg <= key_sum_next;
            val_sum_reg <= val_sum_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/log_record_deframer_core.sv =====
// Bytes pass the input register, then the result register, at one byte per cycle unless
// out_ready stalls them; the input register refills in the same cycle it drains.
// Each byte costs one pass through the parser: length shift, length sums and total compare.
// Reset (rst_n, asynchronous, active low) empties both registers, and the parser
// returns to expecting a total length field with halt cleared.
// Top level of the log record deframer; depends on lrd_pkg and lrd_parser.
`default_nettype none

module log_record_deframer_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [7:0]        log_byte,
    input  wire logic              log_start,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [7:0]        out_byte,
    output      lrd_pkg::role_t    byte_role,
    output      logic              record_done,
    output      lrd_pkg::kind_t    record_kind,
    output      logic              corrupt
);
    import lrd_pkg::*;

    // Input register: holds one accepted transaction ahead of the parser.
    item_t   item_reg;
    logic    item_valid_reg;

    // Result register: holds one tagged byte until the sink takes it.
    result_t result_reg;
    logic    out_valid_reg;

    result_t result_next;
    logic    advance;

    // Advance the held byte into the result register whenever that slot is
    // free or drains in this cycle; the parser state moves with it.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    lrd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_reg),
        .advance (advance),
        .result  (result_next)
    );

    // Valid flags: reset clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transaction, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.data  <= log_byte;
            item_reg.start <= log_start;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = result_reg.data;
    assign byte_role   = result_reg.role;
    assign record_done = result_reg.done;
    assign record_kind = result_reg.kind;
    assign corrupt     = result_reg.bad;

endmodule

`default_nettype wire

// ===== bench/log_record_deframer_core_tb.sv =====
// Self-checking testbench for log_record_deframer_core: streams write-ahead log bytes,
// predicts the tag of every byte with a local deframer model and checks each result.
// Depends on lrd_pkg and the log_record_deframer_core RTL.
module log_record_deframer_core_tb;
    import lrd_pkg::*;

    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;

    typedef enum logic [2:0] {
        AT_TOTAL, AT_CMD, AT_KEYLEN, AT_KEY, AT_VALLEN, AT_VALUE
    } parse_step_t;

    // One row of the directed table; tag is used only where typed is set.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        result_t    tag;
    } dir_row_t;

    localparam result_t NO_TAG = '0;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] log_byte  = 8'h00;
    logic       log_start = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    role_t      byte_role;
    logic       record_done;
    kind_t      record_kind;
    logic       corrupt;

    log_record_deframer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .log_byte    (log_byte),
        .log_start   (log_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_role   (byte_role),
        .record_done (record_done),
        .record_kind (record_kind),
        .corrupt     (corrupt)
    );

    // Deframer state mirrored by the predictor.
    parse_step_t parse_at;
    logic [1:0]  len_byte_idx;
    len_t        frame_total;
    len_t        key_len;
    len_t        val_len;
    len_t        bytes_left;
    logic [7:0]  cmd_code;
    logic        parse_halted;

    dir_row_t    dir_table [DIR_ROWS];
    item_t       log_stream [$];
    logic [7:0]  rec_bytes [$];
    result_t     expected_tags [$];
    logic        fresh_log;

    result_t     predicted_tag;
    result_t     due_tag;
    int          send_pos     = 0;
    int          next_pos     = 0;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int          hold_count   = 0;
    int          cycle_count  = 0;
    logic        hold_off     = 1'b0;
    logic        hold_done    = 1'b0;
    logic        calm         = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic reset_parser();
        parse_at     = AT_TOTAL;
        len_byte_idx = '0;
        frame_total  = '0;
        key_len      = '0;
        val_len      = '0;
        bytes_left   = '0;
        cmd_code     = '0;
        parse_halted = 1'b0;
    endtask

    // Shift one byte into a big-endian length field; flag the field's last byte.
    task automatic shift_len(inout len_t acc, input logic [7:0] b, output logic last);
        acc          = len_t'({acc, b});
        last         = (len_byte_idx == 2'd3);
        len_byte_idx = len_byte_idx + 2'd1;
    endtask

    // Check set and remove totals with wrapping sums; pass other commands as is.
    task automatic close_record(inout result_t tag);
        len_t want;
        if (cmd_code == CMD_SET || cmd_code == CMD_REMOVE)
        begin
            want = CMD_KEYLEN_BYTES + key_len;
            if (cmd_code == CMD_SET)
                want = want + LEN_FIELD_BYTES + val_len;
            if (want != frame_total)
            begin
                tag.bad      = 1'b1;
                parse_halted = 1'b1;
            end
            else
            begin
                tag.done = 1'b1;
                tag.kind = (cmd_code == CMD_SET) ? KIND_SET : KIND_REMOVE;
            end
        end
        else
        begin
            tag.done = 1'b1;
            tag.kind = KIND_OTHER;
        end
        parse_at     = AT_TOTAL;
        len_byte_idx = '0;
        frame_total  = '0;
    endtask

    task automatic finish_key(inout result_t tag);
        if (cmd_code == CMD_SET)
        begin
            parse_at     = AT_VALLEN;
            len_byte_idx = '0;
            val_len      = '0;
        end
        else
            close_record(tag);
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic st, output result_t tag);
        logic last;
        tag      = NO_TAG;
        tag.data = b;
        if (st)
            reset_parser();
        if (parse_halted)
            tag.role = ROLE_IGNORED;
        else
        begin
            case (parse_at)
                AT_CMD:
                begin
                    cmd_code     = b;
                    key_len      = '0;
                    len_byte_idx = '0;
                    parse_at     = AT_KEYLEN;
                end
                AT_KEYLEN:
                begin
                    shift_len(key_len, b, last);
                    if (last)
                    begin
                        if (key_len != '0)
                        begin
                            bytes_left = key_len;
                            parse_at   = AT_KEY;
                        end
                        else
                            finish_key(tag);
                    end
                end
                AT_KEY:
                begin
                    tag.role   = ROLE_KEY;
                    bytes_left = bytes_left - len_t'(1);
                    if (bytes_left == '0)
                        finish_key(tag);
                end
                AT_VALLEN:
                begin
                    shift_len(val_len, b, last);
                    if (last)
                    begin
                        if (val_len != '0)
                        begin
                            bytes_left = val_len;
                            parse_at   = AT_VALUE;
                        end
                        else
                            close_record(tag);
                    end
                end
                AT_VALUE:
                begin
                    tag.role   = ROLE_VALUE;
                    bytes_left = bytes_left - len_t'(1);
                    if (bytes_left == '0)
                        close_record(tag);
                end
                default:
                begin
                    shift_len(frame_total, b, last);
                    if (last)
                        parse_at = AT_CMD;
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic push_byte(input logic [7:0] b);
        log_stream.push_back(item_t'{data: b, start: fresh_log});
        fresh_log = 1'b0;
    endtask

    task automatic add_len(input logic [31:0] v);
        int i;
        for (i = 3; i >= 0; i--)
            rec_bytes.push_back(v[8*i +: 8]);
    endtask

    // Mostly short sections, now and then a long one.
    function automatic int unsigned pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 300) : $urandom_range(0, 5);
    endfunction

    // Append one record: well formed set, remove or other, a corrupt one with
    // trailing garbage, or a truncated one cut off by the next log start.
    task automatic add_record();
        int unsigned pick;
        int unsigned klen;
        int unsigned vlen;
        int unsigned keep;
        int          i;
        logic [7:0]  cmd;
        logic [31:0] total;
        pick = $urandom_range(0, 99);
        klen = pick_len();
        vlen = pick_len();
        if (pick >= 60 && pick < 75)
        begin
            cmd = 8'($urandom_range(0, 255));
            if (cmd == CMD_SET || cmd == CMD_REMOVE)
                cmd = cmd ^ 8'h80;
            total = $urandom;
        end
        else
        begin
            cmd   = $urandom_range(0, 1) ? CMD_SET : CMD_REMOVE;
            total = (cmd == CMD_SET) ? 32'(9 + klen + vlen) : 32'(5 + klen);
            // Corrupt: the low byte of the offset is never zero, so the check fails.
            if (pick >= 75 && pick < 88)
                total = total + {($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'h0,
                                 8'($urandom_range(1, 255))};
        end
        rec_bytes.delete();
        add_len(total);
        rec_bytes.push_back(cmd);
        add_len(klen);
        repeat (klen) rec_bytes.push_back(8'($urandom));
        if (cmd == CMD_SET)
        begin
            add_len(vlen);
            repeat (vlen) rec_bytes.push_back(8'($urandom));
        end
        keep = (pick >= 88) ? $urandom_range(1, rec_bytes.size() - 1) : rec_bytes.size();
        for (i = 0; i < keep; i++)
            push_byte(rec_bytes[i]);
        if (pick >= 75 && pick < 88)
        begin
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
            fresh_log = 1'b1;
        end
        else if (pick >= 88 || $urandom_range(0, 14) == 0)
            fresh_log = 1'b1;
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one; none while calm.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- sender

    // Predict on every accepted transaction; load the next byte once the slot is free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(log_byte, log_start, predicted_tag);
                if (send_pos < DIR_ROWS && dir_table[send_pos].typed)
                    predicted_tag = dir_table[send_pos].tag;
                expected_tags.push_back(predicted_tag);
                send_pos++;
                if ($urandom_range(0, 99) == 0)
                    calm = !calm;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (next_pos < log_stream.size())
                begin
                    in_valid  <= 1'b1;
                    log_byte  <= log_stream[next_pos].data;
                    log_start <= log_stream[next_pos].start;
                    next_pos++;
                    tx_gap = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tags.size() == 0)
                    note_mismatch("result with nothing expected", 32'(out_byte), 32'd0);
                else
                begin
                    due_tag = expected_tags.pop_front();
                    if (out_byte !== due_tag.data)
                        note_mismatch("out_byte", 32'(out_byte), 32'(due_tag.data));
                    if (byte_role !== due_tag.role)
                        note_mismatch("byte_role", 32'(byte_role), 32'(due_tag.role));
                    if (record_done !== due_tag.done)
                        note_mismatch("record_done", 32'(record_done), 32'(due_tag.done));
                    if (record_kind !== due_tag.kind)
                        note_mismatch("record_kind", 32'(record_kind), 32'(due_tag.kind));
                    if (corrupt !== due_tag.bad)
                        note_mismatch("corrupt", 32'(corrupt), 32'(due_tag.bad));
                end
                results_seen++;
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (rx_gap != 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                rx_gap = draw_gap();
                out_ready <= (rx_gap == 0);
            end
        end
    end

    // Hold off the receiver once for a long stretch so the block fills and stalls.
    always @(posedge clk)
    begin
        if (rst_n && !hold_done && results_seen >= HOLD_AFTER)
        begin
            if (hold_count == HOLD_CYCLES)
            begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            else
            begin
                hold_off   <= 1'b1;
                hold_count <= hold_count + 1;
            end
        end
    end

    // ---------------------------------------------------------------- control

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        reset_parser();
        dir_table = '{
            // log opens: set record with empty key and empty value, total 9
            '{8'h00, 1'b1, 1'b1, '{8'h00, ROLE_HEADER, 1'b0, KIND_SET, 1'b0}},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h09, 1'b0, 1'b0, NO_TAG},
            '{8'h01, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            // last value length byte closes the set record
            '{8'h00, 1'b0, 1'b1, '{8'h00, ROLE_HEADER, 1'b1, KIND_SET, 1'b0}},
            // remove record with empty key but total 0: length check fails
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h03, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b0, NO_TAG},
            '{8'h00, 1'b0, 1'b1, '{8'h00, ROLE_HEADER, 1'b0, KIND_SET, 1'b1}},
            // halted: bytes are ignored until the next log start
            '{8'hFF, 1'b0, 1'b1, '{8'hFF, ROLE_IGNORED, 1'b0, KIND_SET, 1'b0}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, ROLE_IGNORED, 1'b0, KIND_SET, 1'b0}},
            // log start clears the halt and begins a total length field
            '{8'hFF, 1'b1, 1'b1, '{8'hFF, ROLE_HEADER, 1'b0, KIND_SET, 1'b0}}
        };
        foreach (dir_table[i])
            log_stream.push_back(item_t'{data: dir_table[i].data, start: dir_table[i].start});
        fresh_log = 1'b1;
        while (log_stream.size() < DIR_ROWS + RANDOM_ITEMS)
            add_record();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (send_pos < log_stream.size() || expected_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lrd_pkg.sv
src/lrd_parser.sv
src/log_record_deframer_core.sv
bench/log_record_deframer_core_tb.sv
